@@ rtl/ty86_pkg.sv @@
package ty86_pkg;

   localparam int PROG_DEPTH_DEF = 128;
   localparam int REG_COUNT_DEF  = 8;
   localparam int MEM_DEPTH_DEF  = 16;

   typedef enum logic [3:0] {
      OP_HALT  = 4'd0,
      OP_ADDQ  = 4'd1,
      OP_SUBQ  = 4'd2,
      OP_CMPQ  = 4'd3,
      OP_JE    = 4'd4,
      OP_JNE   = 4'd5,
      OP_JG    = 4'd6,
      OP_JL    = 4'd7,
      OP_RRMOV = 4'd8,
      OP_IRMOV = 4'd9,
      OP_RMMOV = 4'd10,
      OP_MRMOV = 4'd11
   } op_type;

   typedef struct packed {
      logic [3:0]        mode;
      logic [2:0]        src_reg;
      logic [2:0]        dst_reg;
      logic signed [7:0] immediate;
      logic [2:0]        base_reg;
      logic signed [7:0] offset;
      logic [6:0]        jump_target;
   } instr_type;

   typedef struct packed {
      logic [6:0]        next_pc;
      logic              halted;
      logic              bad_opcode;
      logic              zero_flag;
      logic              sign_flag;
      logic              overflow_flag;
      logic signed [7:0] result_value;
   } result_type;

endpackage

@@ rtl/ty86_req_stage.sv @@
module ty86_req_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ty86_pkg::instr_type   req_instr,
   input  logic                  take,
   output logic                  instr_valid,
   output ty86_pkg::instr_type   instr
);

   logic                valid_ff;
   logic                valid_in;
   ty86_pkg::instr_type instr_ff;

   assign req_ready   = !valid_ff || take;
   assign valid_in    = req_valid || (valid_ff && !take);
   assign instr_valid = valid_ff;
   assign instr       = instr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         instr_ff <= req_instr;
      end
   end

endmodule

@@ rtl/ty86_exec_core.sv @@
module ty86_exec_core #(
   parameter int PROG_DEPTH = ty86_pkg::PROG_DEPTH_DEF,
   parameter int REG_COUNT  = ty86_pkg::REG_COUNT_DEF,
   parameter int MEM_DEPTH  = ty86_pkg::MEM_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  exec_fire,
   input  ty86_pkg::instr_type   instr,
   output ty86_pkg::result_type  result
);

   localparam int RIDX_W = $clog2(REG_COUNT);
   localparam int AW     = $clog2(MEM_DEPTH);
   localparam int PCW    = $clog2(PROG_DEPTH);
   localparam int BIAS   = MEM_DEPTH * ((256 + MEM_DEPTH - 1) / MEM_DEPTH);
   localparam int VMAX   = 254 + BIAS;
   localparam int QW     = $clog2(VMAX / MEM_DEPTH + 1);

   logic [7:0]     reg_file_ff [REG_COUNT];
   logic [7:0]     mem_ff      [MEM_DEPTH];
   logic           zf_ff, sf_ff, of_ff, stopped_ff;
   logic [PCW-1:0] pc_ff;

   logic           zf_in, sf_in, of_in, stopped_in;
   logic [PCW-1:0] pc_in;

   logic [RIDX_W-1:0] ra, rb, rbase;
   logic [7:0]        a_val, b_val, base_val, diff;
   logic [10:0]       addr_sum;
   logic [10:0]       addr_rem;
   logic [AW-1:0]     addr;
   logic [23:0]       tgt_rem;
   logic [PCW-1:0]    target;
   logic [PCW-1:0]    pc_inc;
   logic [PCW+6:0]    pc_wide;
   logic              rf_we, mem_we, bad, jump, advance;
   logic [7:0]        written;

   function automatic logic [RIDX_W-1:0] reg_idx(input logic [2:0] r);
      logic [6:0] t;
      t = {4'b0, r};
      for (int k = 2; k >= 0; k--) begin
         if (t >= (7'(REG_COUNT) << k)) begin
            t = t - (7'(REG_COUNT) << k);
         end
      end
      return t[RIDX_W-1:0];
   endfunction

   always_comb begin
      ra       = reg_idx(instr.src_reg);
      rb       = reg_idx(instr.dst_reg);
      rbase    = reg_idx(instr.base_reg);
      a_val    = reg_file_ff[ra];
      b_val    = reg_file_ff[rb];
      base_val = reg_file_ff[rbase];
      diff     = b_val - a_val;

      addr_sum = {{3{base_val[7]}}, base_val} + {{3{instr.offset[7]}}, instr.offset}
                 + 11'(BIAS);
      addr_rem = addr_sum;
      for (int k = QW - 1; k >= 0; k--) begin
         if (addr_rem >= (11'(MEM_DEPTH) << k)) begin
            addr_rem = addr_rem - (11'(MEM_DEPTH) << k);
         end
      end
      addr = addr_rem[AW-1:0];

      tgt_rem = {17'b0, instr.jump_target};
      for (int k = 6; k >= 0; k--) begin
         if (tgt_rem >= (24'(PROG_DEPTH) << k)) begin
            tgt_rem = tgt_rem - (24'(PROG_DEPTH) << k);
         end
      end
      target = tgt_rem[PCW-1:0];
      pc_inc = (pc_ff == PCW'(PROG_DEPTH - 1)) ? '0 : pc_ff + 1'b1;
   end

   always_comb begin
      zf_in      = zf_ff;
      sf_in      = sf_ff;
      of_in      = of_ff;
      stopped_in = stopped_ff;
      rf_we      = 1'b0;
      mem_we     = 1'b0;
      bad        = 1'b0;
      jump       = 1'b0;
      advance    = 1'b1;
      written    = 8'd0;
      if (stopped_ff) begin
         advance = 1'b0;
      end else begin
         unique case (ty86_pkg::op_type'(instr.mode))
            ty86_pkg::OP_HALT: begin
               stopped_in = 1'b1;
               advance    = 1'b0;
            end
            ty86_pkg::OP_ADDQ: begin
               written = b_val + a_val;
               rf_we   = 1'b1;
            end
            ty86_pkg::OP_SUBQ: begin
               written = diff;
               rf_we   = 1'b1;
            end
            ty86_pkg::OP_CMPQ: begin
               zf_in = (diff == 8'd0);
               sf_in = diff[7];
               of_in = ((b_val[7] ^ a_val[7]) & (b_val[7] ^ diff[7]));
            end
            ty86_pkg::OP_JE:  jump = zf_ff;
            ty86_pkg::OP_JNE: jump = !zf_ff;
            ty86_pkg::OP_JG:  jump = !(sf_ff ^ of_ff) && !zf_ff;
            ty86_pkg::OP_JL:  jump = sf_ff ^ of_ff;
            ty86_pkg::OP_RRMOV: begin
               written = a_val;
               rf_we   = 1'b1;
            end
            ty86_pkg::OP_IRMOV: begin
               written = instr.immediate;
               rf_we   = 1'b1;
            end
            ty86_pkg::OP_RMMOV: begin
               written = a_val;
               mem_we  = 1'b1;
            end
            ty86_pkg::OP_MRMOV: begin
               written = mem_ff[addr];
               rf_we   = 1'b1;
            end
            default: begin
               bad     = 1'b1;
               advance = 1'b0;
            end
         endcase
      end
      if (jump) begin
         pc_in = target;
      end else if (advance) begin
         pc_in = pc_inc;
      end else begin
         pc_in = pc_ff;
      end
      pc_wide = (PCW + 7)'(pc_in);
   end

   always_comb begin
      result.next_pc       = pc_wide[6:0];
      result.halted        = stopped_in;
      result.bad_opcode    = bad;
      result.zero_flag     = zf_in;
      result.sign_flag     = sf_in;
      result.overflow_flag = of_in;
      result.result_value  = written;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            reg_file_ff[i] <= 8'd0;
         end
         for (int i = 0; i < MEM_DEPTH; i++) begin
            mem_ff[i] <= 8'd0;
         end
         zf_ff      <= 1'b0;
         sf_ff      <= 1'b0;
         of_ff      <= 1'b0;
         stopped_ff <= 1'b0;
         pc_ff      <= '0;
      end else if (exec_fire) begin
         if (rf_we) begin
            reg_file_ff[rb] <= written;
         end
         if (mem_we) begin
            mem_ff[addr] <= written;
         end
         zf_ff      <= zf_in;
         sf_ff      <= sf_in;
         of_ff      <= of_in;
         stopped_ff <= stopped_in;
         pc_ff      <= pc_in;
      end
   end

endmodule

@@ rtl/tiny_y86_execute_unit.sv @@
// An accepted req beat is captured in the input register, executed, and held in the
// result register that drives rsp_valid. Throughput: one instruction per cycle while
// rsp_ready does not stall the result register; registers and memory update in execute.
// Reset (synchronous, active high) clears registers, data memory, flags, program
// counter and the halted state, and empties both stages.
module tiny_y86_execute_unit #(
   parameter int PROG_DEPTH = ty86_pkg::PROG_DEPTH_DEF,
   parameter int REG_COUNT  = ty86_pkg::REG_COUNT_DEF,
   parameter int MEM_DEPTH  = ty86_pkg::MEM_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [3:0]        req_mode,
   input  logic [2:0]        req_src_reg,
   input  logic [2:0]        req_dst_reg,
   input  logic signed [7:0] req_immediate,
   input  logic [2:0]        req_base_reg,
   input  logic signed [7:0] req_offset,
   input  logic [6:0]        req_jump_target,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [6:0]        rsp_next_pc,
   output logic              rsp_halted,
   output logic              rsp_bad_opcode,
   output logic              rsp_zero_flag,
   output logic              rsp_sign_flag,
   output logic              rsp_overflow_flag,
   output logic signed [7:0] rsp_result_value
);

   ty86_pkg::instr_type  req_instr;
   ty86_pkg::instr_type  instr;
   ty86_pkg::result_type result;
   ty86_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff;
   logic                 instr_valid;
   logic                 exec_fire;

   always_comb begin
      req_instr.mode        = req_mode;
      req_instr.src_reg     = req_src_reg;
      req_instr.dst_reg     = req_dst_reg;
      req_instr.immediate   = req_immediate;
      req_instr.base_reg    = req_base_reg;
      req_instr.offset      = req_offset;
      req_instr.jump_target = req_jump_target;
   end

   assign exec_fire = instr_valid && (!rsp_valid_ff || rsp_ready);

   ty86_req_stage u_req_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_instr   (req_instr),
      .take        (exec_fire),
      .instr_valid (instr_valid),
      .instr       (instr)
   );

   ty86_exec_core #(
      .PROG_DEPTH (PROG_DEPTH),
      .REG_COUNT  (REG_COUNT),
      .MEM_DEPTH  (MEM_DEPTH)
   ) u_exec_core (
      .clock     (clock),
      .reset     (reset),
      .exec_fire (exec_fire),
      .instr     (instr),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (exec_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_pc       = rsp_ff.next_pc;
   assign rsp_halted        = rsp_ff.halted;
   assign rsp_bad_opcode    = rsp_ff.bad_opcode;
   assign rsp_zero_flag     = rsp_ff.zero_flag;
   assign rsp_sign_flag     = rsp_ff.sign_flag;
   assign rsp_overflow_flag = rsp_ff.overflow_flag;
   assign rsp_result_value  = rsp_ff.result_value;

endmodule

@@ bench/tb_tiny_y86_execute_unit.sv @@
module tb_tiny_y86_execute_unit;
   import ty86_pkg::*;

   localparam logic [3:0] MODE_BAD_LO = 4'd12;
   localparam logic [3:0] MODE_BAD_HI = 4'd15;
   localparam int RANDOM_BEATS = 1700;
   localparam int PHASE_BEATS = 96;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [6:0] rsp_next_pc;
   logic rsp_halted;
   logic rsp_bad_opcode;
   logic rsp_zero_flag;
   logic rsp_sign_flag;
   logic rsp_overflow_flag;
   logic signed [7:0] rsp_result_value;

   instr_type req_beat = '0;
   result_type rsp_beat;

   instr_type instr_backlog[$];
   result_type predicted_results[$];

   logic [7:0] arch_regs[8];
   logic [7:0] arch_mem[16];
   logic arch_zf = 1'b0;
   logic arch_sf = 1'b0;
   logic arch_of = 1'b0;
   logic [6:0] arch_pc = '0;
   logic arch_stopped = 1'b0;

   int reset_count = 0;
   int beats_sent = 0;
   int stall_phase;
   int error_count = 0;
   logic drv_fire;
   logic drv_idle;
   logic mon_stall;
   result_type mon_want;

   assign stall_phase = (beats_sent / PHASE_BEATS) % 4;
   assign rsp_beat = {rsp_next_pc, rsp_halted, rsp_bad_opcode, rsp_zero_flag,
                      rsp_sign_flag, rsp_overflow_flag, rsp_result_value};

   tiny_y86_execute_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_beat.mode),
      .req_src_reg       (req_beat.src_reg),
      .req_dst_reg       (req_beat.dst_reg),
      .req_immediate     (req_beat.immediate),
      .req_base_reg      (req_beat.base_reg),
      .req_offset        (req_beat.offset),
      .req_jump_target   (req_beat.jump_target),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_halted        (rsp_halted),
      .rsp_bad_opcode    (rsp_bad_opcode),
      .rsp_zero_flag     (rsp_zero_flag),
      .rsp_sign_flag     (rsp_sign_flag),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_result_value  (rsp_result_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset_count < RESET_CYCLES) begin
         reset_count <= reset_count + 1;
      end
      reset <= (reset_count < RESET_CYCLES - 1);
   end

   function automatic result_type execute_instr(instr_type beat);
      result_type res;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] t;
      logic [3:0] addr;
      logic take;
      logic step;
      res = '0;
      take = 1'b0;
      step = 1'b1;
      if (!arch_stopped) begin
         a = arch_regs[beat.src_reg];
         b = arch_regs[beat.dst_reg];
         addr = 4'(arch_regs[beat.base_reg] + beat.offset);
         case (beat.mode)
            OP_HALT: begin
               arch_stopped = 1'b1;
               step = 1'b0;
            end
            OP_ADDQ: begin
               res.result_value = b + a;
               arch_regs[beat.dst_reg] = res.result_value;
            end
            OP_SUBQ: begin
               res.result_value = b - a;
               arch_regs[beat.dst_reg] = res.result_value;
            end
            OP_CMPQ: begin
               t = b - a;
               arch_zf = (t == 8'h00);
               arch_sf = t[7];
               arch_of = (b[7] ^ a[7]) & (b[7] ^ t[7]);
            end
            OP_JE:  take = arch_zf;
            OP_JNE: take = !arch_zf;
            OP_JG:  take = !(arch_sf ^ arch_of) && !arch_zf;
            OP_JL:  take = arch_sf ^ arch_of;
            OP_RRMOV: begin
               res.result_value = a;
               arch_regs[beat.dst_reg] = a;
            end
            OP_IRMOV: begin
               res.result_value = beat.immediate;
               arch_regs[beat.dst_reg] = beat.immediate;
            end
            OP_RMMOV: begin
               res.result_value = a;
               arch_mem[addr] = a;
            end
            OP_MRMOV: begin
               res.result_value = arch_mem[addr];
               arch_regs[beat.dst_reg] = arch_mem[addr];
            end
            default: begin
               res.bad_opcode = 1'b1;
               step = 1'b0;
            end
         endcase
         if (take) begin
            arch_pc = beat.jump_target;
         end else if (step) begin
            arch_pc = arch_pc + 7'd1;
         end
      end
      res.next_pc = arch_pc;
      res.halted = arch_stopped;
      res.zero_flag = arch_zf;
      res.sign_flag = arch_sf;
      res.overflow_flag = arch_of;
      return res;
   endfunction

   function automatic instr_type mk_instr(logic [3:0] mode, logic [2:0] ra, logic [2:0] rb,
                                          logic signed [7:0] imm, logic [2:0] base,
                                          logic signed [7:0] off, logic [6:0] tgt);
      instr_type beat;
      beat.mode = mode;
      beat.src_reg = ra;
      beat.dst_reg = rb;
      beat.immediate = imm;
      beat.base_reg = base;
      beat.offset = off;
      beat.jump_target = tgt;
      return beat;
   endfunction

   function automatic instr_type rand_instr(logic [3:0] mode);
      return mk_instr(mode, 3'($urandom), 3'($urandom), 8'($urandom), 3'($urandom),
                      8'($urandom), 7'($urandom));
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         drv_fire = req_valid && req_ready;
         if (drv_fire) begin
            predicted_results.push_back(execute_instr(req_beat));
            beats_sent <= beats_sent + 1;
         end
         if (!(req_valid && !drv_fire)) begin
            drv_idle = (stall_phase == 1 && $urandom_range(99) < 76) ||
                       (stall_phase == 3 && $urandom_range(99) < 25);
            if (instr_backlog.size() != 0 && !drv_idle) begin
               req_beat <= instr_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_results.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_beat);
            error_count++;
         end else begin
            mon_want = predicted_results.pop_front();
            check_field("next_pc", 8'(mon_want.next_pc), 8'(rsp_beat.next_pc));
            check_field("halted", 8'(mon_want.halted), 8'(rsp_beat.halted));
            check_field("bad_opcode", 8'(mon_want.bad_opcode), 8'(rsp_beat.bad_opcode));
            check_field("zero_flag", 8'(mon_want.zero_flag), 8'(rsp_beat.zero_flag));
            check_field("sign_flag", 8'(mon_want.sign_flag), 8'(rsp_beat.sign_flag));
            check_field("overflow_flag", 8'(mon_want.overflow_flag),
                        8'(rsp_beat.overflow_flag));
            check_field("result_value", mon_want.result_value, rsp_beat.result_value);
         end
      end
      mon_stall = (stall_phase == 2 && $urandom_range(99) < 76) ||
                  (stall_phase == 3 && $urandom_range(99) < 25);
      rsp_ready <= !mon_stall;
   end

   initial begin
      int kind;
      int gap;
      logic [2:0] ra;
      logic [2:0] rb;
      instr_type store;
      for (int i = 0; i < 8; i++) begin
         arch_regs[i] = '0;
      end
      for (int i = 0; i < 16; i++) begin
         arch_mem[i] = '0;
      end

      instr_backlog.push_back(mk_instr(OP_IRMOV, 0, 0, 127, 0, 0, 0));
      instr_backlog.push_back(mk_instr(OP_IRMOV, 0, 1, -128, 0, 0, 0));
      instr_backlog.push_back(mk_instr(OP_IRMOV, 0, 7, 1, 0, 0, 0));
      instr_backlog.push_back(mk_instr(OP_ADDQ, 7, 0, 0, 0, 0, 0));
      instr_backlog.push_back(mk_instr(OP_SUBQ, 7, 1, 0, 0, 0, 0));
      instr_backlog.push_back(mk_instr(OP_CMPQ, 7, 1, 0, 0, 0, 0));
      instr_backlog.push_back(mk_instr(OP_JG, 0, 0, 0, 0, 0, 127));
      instr_backlog.push_back(mk_instr(OP_JL, 0, 0, 0, 0, 0, 0));
      instr_backlog.push_back(mk_instr(OP_CMPQ, 7, 0, 0, 0, 0, 0));
      instr_backlog.push_back(mk_instr(OP_JL, 0, 0, 0, 0, 0, 5));
      instr_backlog.push_back(mk_instr(OP_CMPQ, 7, 7, 0, 0, 0, 0));
      // taken branch to its own program counter value
      instr_backlog.push_back(mk_instr(OP_JE, 0, 0, 0, 0, 0, 6));
      instr_backlog.push_back(mk_instr(OP_JNE, 0, 0, 0, 0, 0, 0));
      instr_backlog.push_back(mk_instr(OP_JG, 0, 0, 0, 0, 0, 100));
      instr_backlog.push_back(mk_instr(OP_RMMOV, 0, 0, 0, 1, 127, 0));
      instr_backlog.push_back(mk_instr(OP_RMMOV, 7, 0, 0, 0, -128, 0));
      instr_backlog.push_back(mk_instr(OP_MRMOV, 0, 3, 0, 1, 127, 0));
      instr_backlog.push_back(mk_instr(OP_RRMOV, 3, 4, 0, 0, 0, 0));
      instr_backlog.push_back(rand_instr(MODE_BAD_LO));
      instr_backlog.push_back(rand_instr(MODE_BAD_HI));
      instr_backlog.push_back(mk_instr(OP_MRMOV, 0, 5, 0, 2, 3, 0));
      instr_backlog.push_back(mk_instr(OP_CMPQ, 0, 7, 0, 0, 0, 0));
      instr_backlog.push_back(mk_instr(OP_JL, 0, 0, 0, 0, 0, 33));
      instr_backlog.push_back(mk_instr(OP_JG, 0, 0, 0, 0, 0, 64));

      while (instr_backlog.size() < RANDOM_BEATS) begin
         kind = $urandom_range(9);
         if (kind <= 2) begin
            ra = 3'($urandom);
            rb = 3'($urandom);
            instr_backlog.push_back(mk_instr(OP_IRMOV, 0, ra, 8'($urandom), 0, 0, 0));
            store = rand_instr(OP_IRMOV);
            store.dst_reg = rb;
            if ($urandom_range(3) == 0) begin
               store.immediate = instr_backlog[$].immediate;
            end
            instr_backlog.push_back(store);
            store = rand_instr(OP_CMPQ);
            store.src_reg = ra;
            store.dst_reg = rb;
            instr_backlog.push_back(store);
            instr_backlog.push_back(rand_instr(4'($urandom_range(OP_JL, OP_JE))));
         end else if (kind <= 4) begin
            store = rand_instr(OP_RMMOV);
            instr_backlog.push_back(store);
            gap = $urandom_range(3);
            repeat (gap) instr_backlog.push_back(rand_instr(4'($urandom_range(OP_MRMOV,
                                                                              OP_ADDQ))));
            store.mode = OP_MRMOV;
            store.dst_reg = 3'($urandom);
            instr_backlog.push_back(store);
         end else if (kind == 5) begin
            instr_backlog.push_back(rand_instr(4'($urandom_range(MODE_BAD_HI, MODE_BAD_LO))));
         end else begin
            instr_backlog.push_back(rand_instr(4'($urandom_range(OP_MRMOV, OP_ADDQ))));
         end
      end

      instr_backlog.push_back(rand_instr(OP_HALT));
      instr_backlog.push_back(rand_instr(OP_ADDQ));
      instr_backlog.push_back(rand_instr(MODE_BAD_LO));
      instr_backlog.push_back(rand_instr(OP_JE));
      instr_backlog.push_back(rand_instr(OP_HALT));

      while (instr_backlog.size() != 0 || req_valid) @(posedge clock);
      while (predicted_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/ty86_pkg.sv
rtl/ty86_req_stage.sv
rtl/ty86_exec_core.sv
rtl/tiny_y86_execute_unit.sv
bench/tb_tiny_y86_execute_unit.sv
